>>> sv/tna_pkg.sv
// ----------------------------------------------------------------------------
// tna_pkg
// Shared widths and helpers for the triangle normal and area pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package tna_pkg;

  localparam int COORD_W    = 16;
  localparam int DIFF_W     = COORD_W + 1;        // vertex differences
  localparam int PROD_W     = 2 * DIFF_W;         // one cross term
  localparam int CROSS_W    = PROD_W + 1;         // cross component, signed
  localparam int MAG_W      = CROSS_W - 1;        // cross magnitude
  localparam int HALF_W     = MAG_W / 2;          // split for partial products
  localparam int SQ_W       = 2 * MAG_W;          // one square
  localparam int SUM_W      = SQ_W + 2;           // sum of three squares
  localparam int ROOT_W     = SUM_W / 2;          // isqrt result
  localparam int DOT_P_W    = DIFF_W + CROSS_W;   // one dot term
  localparam int DOT_W      = DOT_P_W + 2;        // dot sum
  localparam int FRAC_BITS  = 14;
  localparam int QUO_W      = FRAC_BITS + 1;
  localparam int NORM_W     = 16;
  localparam int AREA_W     = 33;
  localparam int LIMIT_W    = 10;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(7);

  localparam int IN_DATA_W  = 200;
  localparam int OUT_DATA_W = 88;

  // magnitude of a cross component
  function automatic logic [MAG_W-1:0] cross_mag(input logic signed [CROSS_W-1:0] c);
    logic signed [CROSS_W-1:0] n;
    n = -c;
    return c[CROSS_W-1] ? n[MAG_W-1:0] : c[MAG_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> sv/triangle_normal_area.sv
// ----------------------------------------------------------------------------
// triangle_normal_area
// Unit normal, area and orientation of one triangle per beat.
// ----------------------------------------------------------------------------
// One triangle enters on the in_ stream per beat: three vertices and an
// orientation point in signed Q8.8, with the orient enable in bit 192.
// One result leaves on the out_ stream per input beat: the unit normal in
// Q1.14, the area in 2^-16 square units, a small-area flag and a flip flag.
// The pipeline has six arithmetic stages (differences, cross terms,
// cross product, partial squares and dot terms, square and dot sums, total),
// 35 stages of a bit-per-stage square root, 15 stages of three parallel
// bit-per-stage dividers and one output register.
// It takes one triangle per cycle unless the receiver stalls the output.
// The whole pipeline advances together; when the receiver holds out_tready
// low with a result waiting, every stage holds and in_tready drops, so no
// beat is lost or repeated. Synchronous reset clears all valid bits and
// loads the area warn limit with 7; cfg_wr_en writes the limit, and the
// user must use it only while the block idles; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_normal_area (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, ref_x, ref_y, ref_z_orient
  input  wire logic [tna_pkg::IN_DATA_W-1:0]      in_tdata,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // normal_x, normal_y, normal_z, area, small_area, flipped
  output logic [tna_pkg::OUT_DATA_W-1:0]          out_tdata,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  input  wire logic                               cfg_wr_en,
  input  wire logic [tna_pkg::LIMIT_W-1:0]        cfg_wr_data
);
  import tna_pkg::*;

  localparam int SQRT_N = ROOT_W;
  localparam int DIV_N  = QUO_W;

  logic en;
  logic [LIMIT_W-1:0] limit_r;

  // global advance
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      limit_r <= cfg_wr_data;
    end
  end

  // input unpack
  logic signed [COORD_W-1:0] pa [3];
  logic signed [COORD_W-1:0] pb [3];
  logic signed [COORD_W-1:0] pc [3];
  logic signed [COORD_W-1:0] pr [3];
  logic                      orient;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pa[i] = in_tdata[COORD_W*i       +: COORD_W];
      pb[i] = in_tdata[COORD_W*(i + 3) +: COORD_W];
      pc[i] = in_tdata[COORD_W*(i + 6) +: COORD_W];
      pr[i] = in_tdata[COORD_W*(i + 9) +: COORD_W];
    end
    orient = in_tdata[COORD_W*12];
  end

  // stage 1: edge and reference differences
  logic                     s1_v_r;
  logic signed [DIFF_W-1:0] s1_e0_r [3];
  logic signed [DIFF_W-1:0] s1_e1_r [3];
  logic signed [DIFF_W-1:0] s1_d_r  [3];
  logic                     s1_or_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r  <= in_tvalid;
      s1_or_r <= orient;
      for (int i = 0; i < 3; i++) begin
        s1_e0_r[i] <= DIFF_W'(pb[i]) - DIFF_W'(pa[i]);
        s1_e1_r[i] <= DIFF_W'(pc[i]) - DIFF_W'(pa[i]);
        s1_d_r[i]  <= DIFF_W'(pr[i]) - DIFF_W'(pa[i]);
      end
    end
  end

  // stage 2: cross terms
  logic                     s2_v_r;
  logic signed [PROD_W-1:0] s2_p_r [6];
  logic signed [DIFF_W-1:0] s2_d_r [3];
  logic                     s2_or_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r    <= s1_v_r;
      s2_or_r   <= s1_or_r;
      s2_d_r    <= s1_d_r;
      s2_p_r[0] <= s1_e0_r[1] * s1_e1_r[2];
      s2_p_r[1] <= s1_e0_r[2] * s1_e1_r[1];
      s2_p_r[2] <= s1_e0_r[2] * s1_e1_r[0];
      s2_p_r[3] <= s1_e0_r[0] * s1_e1_r[2];
      s2_p_r[4] <= s1_e0_r[0] * s1_e1_r[1];
      s2_p_r[5] <= s1_e0_r[1] * s1_e1_r[0];
    end
  end

  // stage 3: cross product
  logic                      s3_v_r;
  logic signed [CROSS_W-1:0] s3_c_r [3];
  logic signed [DIFF_W-1:0]  s3_d_r [3];
  logic                      s3_or_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r  <= s2_v_r;
      s3_or_r <= s2_or_r;
      s3_d_r  <= s2_d_r;
      for (int i = 0; i < 3; i++) begin
        s3_c_r[i] <= CROSS_W'(s2_p_r[2*i]) - CROSS_W'(s2_p_r[2*i+1]);
      end
    end
  end

  // stage 4: partial squares and dot terms
  logic                      s4_v_r;
  logic [2*HALF_W-1:0]       s4_hh_r [3];
  logic [2*HALF_W-1:0]       s4_hl_r [3];
  logic [2*HALF_W-1:0]       s4_ll_r [3];
  logic signed [DOT_P_W-1:0] s4_dp_r [3];
  logic signed [CROSS_W-1:0] s4_c_r  [3];
  logic                      s4_or_r;
  logic                      s4_nz_r;
  logic [MAG_W-1:0]          s3_mag  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s3_mag[i] = cross_mag(s3_c_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (en) begin
      s4_v_r  <= s3_v_r;
      s4_or_r <= s3_or_r;
      s4_c_r  <= s3_c_r;
      s4_nz_r <= (s3_c_r[0] != '0) || (s3_c_r[1] != '0) || (s3_c_r[2] != '0);
      for (int i = 0; i < 3; i++) begin
        s4_hh_r[i] <= s3_mag[i][MAG_W-1:HALF_W] * s3_mag[i][MAG_W-1:HALF_W];
        s4_hl_r[i] <= s3_mag[i][MAG_W-1:HALF_W] * s3_mag[i][HALF_W-1:0];
        s4_ll_r[i] <= s3_mag[i][HALF_W-1:0] * s3_mag[i][HALF_W-1:0];
        s4_dp_r[i] <= s3_d_r[i] * s3_c_r[i];
      end
    end
  end

  // stage 5: squares and dot sum
  logic                      s5_v_r;
  logic [SQ_W-1:0]           s5_sq_r [3];
  logic signed [CROSS_W-1:0] s5_c_r  [3];
  logic                      s5_flp_r;
  logic                      s5_nz_r;
  logic signed [DOT_W-1:0]   s4_dot;

  assign s4_dot = DOT_W'(s4_dp_r[0]) + DOT_W'(s4_dp_r[1]) + DOT_W'(s4_dp_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else if (en) begin
      s5_v_r   <= s4_v_r;
      s5_c_r   <= s4_c_r;
      s5_nz_r  <= s4_nz_r;
      s5_flp_r <= s4_or_r && !s4_dot[DOT_W-1] && (s4_dot != '0);
      for (int i = 0; i < 3; i++) begin
        s5_sq_r[i] <= (SQ_W'(s4_hh_r[i]) << (2*HALF_W))
                    + (SQ_W'(s4_hl_r[i]) << (HALF_W + 1))
                    + SQ_W'(s4_ll_r[i]);
      end
    end
  end

  // square root pipeline, entry 0 is the squared length
  logic                      sq_v    [SQRT_N+1];
  logic [SUM_W-1:0]          sq_rem  [SQRT_N+1];
  logic [ROOT_W-1:0]         sq_root [SQRT_N+1];
  logic signed [CROSS_W-1:0] sq_c    [SQRT_N+1][3];
  logic                      sq_flp  [SQRT_N+1];
  logic                      sq_nz   [SQRT_N+1];

  // stage 6: squared length
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v[0] <= 1'b0;
    end else if (en) begin
      sq_v[0]    <= s5_v_r;
      sq_rem[0]  <= SUM_W'(s5_sq_r[0]) + SUM_W'(s5_sq_r[1]) + SUM_W'(s5_sq_r[2]);
      sq_root[0] <= '0;
      sq_c[0]    <= s5_c_r;
      sq_flp[0]  <= (s5_flp_r && s5_nz_r);
      sq_nz[0]   <= s5_nz_r;
    end
  end

  // one root bit per stage, most significant first
  for (genvar k = 0; k < SQRT_N; k++) begin : g_sqrt
    localparam int B = SQRT_N - 1 - k;
    logic [SUM_W-1:0] inc;
    logic             take;

    assign inc  = (SUM_W'(sq_root[k]) << (B + 1)) | (SUM_W'(1) << (2*B));
    assign take = sq_rem[k] >= inc;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v[k+1] <= 1'b0;
      end else if (en) begin
        sq_v[k+1]    <= sq_v[k];
        sq_rem[k+1]  <= take ? sq_rem[k] - inc : sq_rem[k];
        sq_root[k+1] <= take ? (sq_root[k] | (ROOT_W'(1) << B)) : sq_root[k];
        sq_c[k+1]    <= sq_c[k];
        sq_flp[k+1]  <= sq_flp[k];
        sq_nz[k+1]   <= sq_nz[k];
      end
    end
  end

  // divider pipeline, three lanes sharing the root
  logic              dv_v   [DIV_N];
  logic [QUO_W-1:0]  dv_q   [DIV_N][3];
  logic [MAG_W-1:0]  dv_rem [DIV_N][3];
  logic              dv_sgn [DIV_N][3];
  logic [ROOT_W-1:0] dv_m   [DIV_N];
  logic              dv_flp [DIV_N];
  logic              dv_nz  [DIV_N];
  logic [MAG_W-1:0]  sq_mag [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_mag[i] = cross_mag(sq_c[SQRT_N][i]);
    end
  end

  // integer quotient bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v[0] <= 1'b0;
    end else if (en) begin
      dv_v[0]   <= sq_v[SQRT_N];
      dv_m[0]   <= sq_root[SQRT_N];
      dv_flp[0] <= sq_flp[SQRT_N];
      dv_nz[0]  <= sq_nz[SQRT_N];
      for (int i = 0; i < 3; i++) begin
        dv_sgn[0][i] <= sq_c[SQRT_N][i][CROSS_W-1];
        if (sq_mag[i] >= sq_root[SQRT_N]) begin
          dv_q[0][i]   <= QUO_W'(1);
          dv_rem[0][i] <= MAG_W'(sq_mag[i] - sq_root[SQRT_N]);
        end else begin
          dv_q[0][i]   <= '0;
          dv_rem[0][i] <= sq_mag[i];
        end
      end
    end
  end

  // one fraction bit per stage
  for (genvar k = 1; k < DIV_N; k++) begin : g_div
    logic [MAG_W:0] r2 [3];
    logic           ge [3];

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        r2[i] = {dv_rem[k-1][i], 1'b0};
        ge[i] = r2[i] >= {1'b0, dv_m[k-1]};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v[k] <= 1'b0;
      end else if (en) begin
        dv_v[k]   <= dv_v[k-1];
        dv_m[k]   <= dv_m[k-1];
        dv_flp[k] <= dv_flp[k-1];
        dv_nz[k]  <= dv_nz[k-1];
        for (int i = 0; i < 3; i++) begin
          dv_sgn[k][i] <= dv_sgn[k-1][i];
          dv_q[k][i]   <= {dv_q[k-1][i][QUO_W-2:0], ge[i]};
          dv_rem[k][i] <= ge[i] ? MAG_W'(r2[i] - {1'b0, dv_m[k-1]}) : MAG_W'(r2[i]);
        end
      end
    end
  end

  // output register
  logic              out_v_r;
  logic [NORM_W-1:0] out_n_r [3];
  logic [AREA_W-1:0] out_area_r;
  logic              out_small_r;
  logic              out_flip_r;
  logic [AREA_W-1:0] fin_area;
  logic [NORM_W-1:0] fin_q [3];

  // root stays below 2^34, so half of it fits the area field
  assign fin_area = dv_m[DIV_N-1][AREA_W:1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fin_q[i] = NORM_W'(dv_q[DIV_N-1][i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r     <= dv_v[DIV_N-1];
      out_flip_r  <= dv_flp[DIV_N-1];
      out_area_r  <= dv_nz[DIV_N-1] ? fin_area : '0;
      out_small_r <= !dv_nz[DIV_N-1] || (fin_area < AREA_W'(limit_r));
      for (int i = 0; i < 3; i++) begin
        if (!dv_nz[DIV_N-1]) begin
          out_n_r[i] <= '0;
        end else if (dv_sgn[DIV_N-1][i] ^ dv_flp[DIV_N-1]) begin
          out_n_r[i] <= -fin_q[i];
        end else begin
          out_n_r[i] <= fin_q[i];
        end
      end
    end
  end

  // result beat
  assign out_tvalid = out_v_r;
  assign out_tdata  = {5'b0, out_flip_r, out_small_r, out_area_r,
                       out_n_r[2], out_n_r[1], out_n_r[0]};

endmodule

`default_nettype wire
